>>> src/rlu_pkg.sv
// ----------------------------------------------------------------------------
// rlu_pkg: shared types and constants of the radial lens undistort remap
// Frame store geometry, register indexes, item and config structs.
// ----------------------------------------------------------------------------
`default_nettype none

package rlu_pkg;

  // frame store geometry
  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);

  // field widths
  localparam int PIX_W  = 6;
  localparam int CH_W   = 8;
  localparam int RGB_W  = 3 * CH_W;
  localparam int COEF_W = 32;
  localparam int CEN_W  = 14;
  localparam int DIM_W  = 7;
  localparam int D_W    = CEN_W + 1;   // signed offset from principal point

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_W;
  localparam logic [CFG_IDX_W-1:0] REG_K1         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_K2         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_COL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 3'd5;

  localparam logic [CEN_W-1:0] RST_CENTER = 14'd512;
  localparam logic [DIM_W-1:0] RST_DIM    = 7'd64;

  // queue and back pipeline
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int NSTG        = 8;

  typedef enum logic {
    CMD_STORE = 1'b0,
    CMD_REMAP = 1'b1
  } cmd_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] k1;
    logic signed [COEF_W-1:0] k2;
    logic [CEN_W-1:0]         center_col;
    logic [CEN_W-1:0]         center_row;
    logic [DIM_W-1:0]         image_width;
    logic [DIM_W-1:0]         image_height;
  } cfg_t;

  typedef struct packed {
    cmd_e                  op;
    logic [ADDR_W-1:0]     waddr;
    logic [RGB_W-1:0]      rgb;
    logic signed [D_W-1:0] du;
    logic signed [D_W-1:0] dv;
  } item_t;

endpackage

`default_nettype wire

>>> src/rlu_front.sv
// ----------------------------------------------------------------------------
// rlu_front: input classifier
// Sorts items into stores and remaps, drops stores outside the frame store,
// and forms the store address and the offsets from the principal point.
// ----------------------------------------------------------------------------
`default_nettype none

module rlu_front
  import rlu_pkg::*;
(
  input  cfg_t             cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             cmd_i,
  input  logic [PIX_W-1:0] pix_col_i,
  input  logic [PIX_W-1:0] pix_row_i,
  input  logic [CH_W-1:0]  in_red_i,
  input  logic [CH_W-1:0]  in_green_i,
  input  logic [CH_W-1:0]  in_blue_i,
  output logic             push_o,
  input  logic             q_ready_i,
  output item_t            item_o
);

  logic in_store;
  logic drop;

  assign in_store = (32'(pix_col_i) < 32'(MAX_WIDTH)) && (32'(pix_row_i) < 32'(MAX_HEIGHT));
  assign drop     = (cmd_e'(cmd_i) == CMD_STORE) && !in_store;

  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i && q_ready_i && !drop;

  always_comb begin
    item_o.op    = cmd_e'(cmd_i);
    item_o.waddr = ADDR_W'(ADDR_W'(pix_row_i) * ADDR_W'(MAX_WIDTH) + ADDR_W'(pix_col_i));
    item_o.rgb   = {in_red_i, in_green_i, in_blue_i};
    // offsets in 1/16 pixel
    item_o.du    = $signed(D_W'({pix_col_i, 4'b0000}))
                   - $signed({1'b0, cfg_i.center_col});
    item_o.dv    = $signed(D_W'({pix_row_i, 4'b0000}))
                   - $signed({1'b0, cfg_i.center_row});
  end

endmodule

`default_nettype wire

>>> src/rlu_queue.sv
// ----------------------------------------------------------------------------
// rlu_queue: short item queue
// Register-based FIFO between the classifier and the remap pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module rlu_queue
  import rlu_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  output logic  not_full_o,
  input  item_t item_i,
  output logic  not_empty_o,
  input  logic  pop_i,
  output item_t item_o
);

  item_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wptr_q, wptr_d;
  logic [QPTR_W-1:0]  rptr_q, rptr_d;
  logic [QPTR_W:0]    cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign not_full_o  = cnt_q != (QPTR_W+1)'(QUEUE_DEPTH);
  assign not_empty_o = cnt_q != '0;
  assign do_push     = push_i && not_full_o;
  assign do_pop      = pop_i && not_empty_o;
  assign item_o      = slot_q[rptr_q];

  always_comb begin
    wptr_d = do_push ? QPTR_W'(wptr_q + 1'b1) : wptr_q;
    rptr_d = do_pop  ? QPTR_W'(rptr_q + 1'b1) : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

>>> src/rlu_back.sv
// ----------------------------------------------------------------------------
// rlu_back: remap pipeline and frame store
// Eight stages: squares, radius, products, k2 term, scale, source offset,
// bounds and address, store access. Stores ride along and write the frame
// store at the same stage where remaps read it, so order is kept.
// ----------------------------------------------------------------------------
`default_nettype none

module rlu_back
  import rlu_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  logic            q_valid_i,
  output logic            q_ready_o,
  input  item_t           q_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [CH_W-1:0] out_red_o,
  output logic [CH_W-1:0] out_green_o,
  output logic [CH_W-1:0] out_blue_o,
  output logic            in_frame_o
);

  // stage positions
  localparam int ST_SQ   = 0;
  localparam int ST_R    = 1;
  localparam int ST_PROD = 2;
  localparam int ST_K2   = 3;
  localparam int ST_C    = 4;
  localparam int ST_P    = 5;
  localparam int ST_LOC  = 6;
  localparam int ST_MEM  = 7;

  // datapath widths
  localparam int SQ_W  = 2 * (D_W - 1);
  localparam int R_W   = SQ_W + 1;
  localparam int RR_W  = 2 * R_W;
  localparam int K1R_W = COEF_W + R_W;
  localparam int RRH_W = RR_W - 32;
  localparam int T_W   = RRH_W + COEF_W;
  localparam int C_W   = 63;
  localparam int C32_W = C_W - 16;
  localparam int P_W   = C32_W + D_W;
  localparam int SX_W  = C_W - 36;

  localparam logic signed [C_W-1:0] C_ONE      = C_W'(64'sd1 <<< 48);
  localparam logic signed [C_W-1:0] TRUNC_BIAS = C_W'((64'sd1 <<< 36) - 64'sd1);

  logic                adv;
  logic [NSTG-1:0]     vld_q;
  item_t               ctl_q [NSTG];

  logic signed [2*D_W-1:0] sq_u, sq_v;
  logic [SQ_W-1:0]         du2_q, dv2_q;
  logic [R_W-1:0]          r_q;
  logic [RR_W-1:0]         rr_q;
  logic signed [K1R_W-1:0] k1r_d, k1r_q, k1r3_q;
  logic signed [T_W-1:0]   t_d, t_q;
  logic signed [C_W-1:0]   csum;
  logic signed [C32_W-1:0] c32_q;
  logic signed [P_W-1:0]   px_d, py_d, px_q, py_q;
  logic signed [C_W-1:0]   sum_x, sum_y, adj_x, adj_y;
  logic signed [SX_W-1:0]  sx, sy, lim_w, lim_h;
  logic                    loc_in;
  logic [ADDR_W-1:0]       raddr_d, raddr_q;
  logic                    frame6_q, frame7_q;
  logic [RGB_W-1:0]        frame_mem_q [STORE_DEPTH];
  logic [RGB_W-1:0]        rd_q;

  assign out_valid_o = vld_q[ST_MEM] && (ctl_q[ST_MEM].op == CMD_REMAP);
  assign adv         = !out_valid_o || out_ready_i;
  assign q_ready_o   = adv;

  always_comb begin
    sq_u  = $signed(q_item_i.du) * $signed(q_item_i.du);
    sq_v  = $signed(q_item_i.dv) * $signed(q_item_i.dv);
    k1r_d = $signed(cfg_i.k1) * $signed({1'b0, r_q});
    t_d   = $signed({1'b0, rr_q[RR_W-1:32]}) * $signed(cfg_i.k2);
    // |k1*R| < 2^60, so the sum never reaches the +-2^61 clamp
    csum  = C_ONE + C_W'(k1r3_q) + C_W'(t_q >>> 8);
    px_d  = $signed(c32_q) * $signed(ctl_q[ST_C].du);
    py_d  = $signed(c32_q) * $signed(ctl_q[ST_C].dv);
  end

  // source coordinate, truncated toward zero, and bounds
  always_comb begin
    sum_x = C_W'(px_q) + C_W'($signed({1'b0, cfg_i.center_col, 32'd0}));
    sum_y = C_W'(py_q) + C_W'($signed({1'b0, cfg_i.center_row, 32'd0}));
    adj_x = sum_x + (sum_x[C_W-1] ? TRUNC_BIAS : '0);
    adj_y = sum_y + (sum_y[C_W-1] ? TRUNC_BIAS : '0);
    sx    = adj_x[C_W-1:36];
    sy    = adj_y[C_W-1:36];
    lim_w = (32'(cfg_i.image_width) < 32'(MAX_WIDTH))
            ? SX_W'(cfg_i.image_width) : SX_W'(MAX_WIDTH);
    lim_h = (32'(cfg_i.image_height) < 32'(MAX_HEIGHT))
            ? SX_W'(cfg_i.image_height) : SX_W'(MAX_HEIGHT);
    loc_in  = !sx[SX_W-1] && (sx < lim_w) && !sy[SX_W-1] && (sy < lim_h);
    raddr_d = ADDR_W'(ADDR_W'(sy[ROW_W-1:0]) * ADDR_W'(MAX_WIDTH)
                      + ADDR_W'(sx[COL_W-1:0]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-2:0], q_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctl_q[0] <= q_item_i;
      for (int i = 1; i < NSTG; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
      du2_q    <= sq_u[SQ_W-1:0];
      dv2_q    <= sq_v[SQ_W-1:0];
      r_q      <= R_W'(du2_q) + R_W'(dv2_q);
      rr_q     <= RR_W'(r_q) * RR_W'(r_q);
      k1r_q    <= k1r_d;
      k1r3_q   <= k1r_q;
      t_q      <= t_d;
      c32_q    <= csum[C_W-1:16];
      px_q     <= px_d;
      py_q     <= py_d;
      frame6_q <= loc_in;
      raddr_q  <= raddr_d;
      frame7_q <= frame6_q;
    end
  end

  // frame store: stores write it at the location stage, where remaps read it
  always_ff @(posedge clk_i) begin
    if (adv && vld_q[ST_LOC] && (ctl_q[ST_LOC].op == CMD_STORE)) begin
      frame_mem_q[ctl_q[ST_LOC].waddr] <= ctl_q[ST_LOC].rgb;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_q <= frame_mem_q[raddr_q];
    end
  end

  assign in_frame_o  = frame7_q;
  assign out_red_o   = frame7_q ? rd_q[RGB_W-1:2*CH_W] : '0;
  assign out_green_o = frame7_q ? rd_q[2*CH_W-1:CH_W]  : '0;
  assign out_blue_o  = frame7_q ? rd_q[CH_W-1:0]       : '0;

endmodule

`default_nettype wire

>>> src/radial_lens_undistort_remap.sv
// ----------------------------------------------------------------------------
// radial_lens_undistort_remap: two-term radial lens backward remap
// Holds an RGB source frame and returns, per requested output pixel, the
// source pixel found through the k1/k2 radial lens model.
// ----------------------------------------------------------------------------
// Usage: a store transfer (cmd 0) writes one RGB pixel into the 64x64 frame
// store; a remap transfer (cmd 1) names an output pixel and yields exactly
// one result transfer, in order. The block takes one item per clock when the
// output side keeps up; an item is registered in the 4-entry queue and then
// passes down the eight-stage pipeline before its result is presented. The
// pipeline stalls as a whole while a result waits on out_ready_i; the queue
// keeps the input side open for up to four items during a stall. Store
// transfers give no result.
// Source coordinates are c*d + centre with c = 1 + k1*r2 + k2*r2^2, k1 in
// 2^-40 and k2 in 2^-72 per pixel power, centre in 1/16 pixel, truncated
// toward zero; a coordinate outside image_width x image_height returns black
// with in_frame_o low. Pixels must be stored before they are read. Write the
// config registers only while the block is idle: 0 k1, 1 k2, 2 center col,
// 3 center row, 4 width, 5 height.
// ----------------------------------------------------------------------------
`default_nettype none

module radial_lens_undistort_remap
  import rlu_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  cmd_i,
  input  logic [PIX_W-1:0]      pix_col_i,
  input  logic [PIX_W-1:0]      pix_row_i,
  input  logic [CH_W-1:0]       in_red_i,
  input  logic [CH_W-1:0]       in_green_i,
  input  logic [CH_W-1:0]       in_blue_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [CH_W-1:0]       out_red_o,
  output logic [CH_W-1:0]       out_green_o,
  output logic [CH_W-1:0]       out_blue_o,
  output logic                  in_frame_o
);

  cfg_t  cfg_q, cfg_d;
  logic  push;
  logic  q_not_full;
  logic  q_not_empty;
  logic  back_ready;
  item_t front_item;
  item_t head_item;

  // config registers, field widths truncate the write data
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_K1:         cfg_d.k1           = $signed(cfg_wdata_i);
        REG_K2:         cfg_d.k2           = $signed(cfg_wdata_i);
        REG_CENTER_COL: cfg_d.center_col   = cfg_wdata_i[CEN_W-1:0];
        REG_CENTER_ROW: cfg_d.center_row   = cfg_wdata_i[CEN_W-1:0];
        REG_WIDTH:      cfg_d.image_width  = cfg_wdata_i[DIM_W-1:0];
        REG_HEIGHT:     cfg_d.image_height = cfg_wdata_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.k1           <= '0;
      cfg_q.k2           <= '0;
      cfg_q.center_col   <= RST_CENTER;
      cfg_q.center_row   <= RST_CENTER;
      cfg_q.image_width  <= RST_DIM;
      cfg_q.image_height <= RST_DIM;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: classify and form offsets
  rlu_front u_front (
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .pix_col_i  (pix_col_i),
    .pix_row_i  (pix_row_i),
    .in_red_i   (in_red_i),
    .in_green_i (in_green_i),
    .in_blue_i  (in_blue_i),
    .push_o     (push),
    .q_ready_i  (q_not_full),
    .item_o     (front_item)
  );

  // decoupling queue
  rlu_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .not_full_o  (q_not_full),
    .item_i      (front_item),
    .not_empty_o (q_not_empty),
    .pop_i       (back_ready),
    .item_o      (head_item)
  );

  // back: lens math, frame store, result register
  rlu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_not_empty),
    .q_ready_o   (back_ready),
    .q_item_i    (head_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o),
    .in_frame_o  (in_frame_o)
  );

endmodule

`default_nettype wire

>>> src/rlu_checker.sv
// ----------------------------------------------------------------------------
// rlu_checker: port-level checks of the remap block
// Tracks remap transfers against result transfers; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rlu_checker
  import rlu_pkg::*;
(
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_valid_i,
  input wire logic            in_ready_o,
  input wire logic            cmd_i,
  input wire logic            out_valid_o,
  input wire logic            out_ready_i,
  input wire logic [CH_W-1:0] out_red_o,
  input wire logic [CH_W-1:0] out_green_o,
  input wire logic [CH_W-1:0] out_blue_o,
  input wire logic            in_frame_o
);

  localparam int PEND_MAX = QUEUE_DEPTH + NSTG;

  logic [7:0] pend_q;
  logic       rq_xfer, out_xfer;

  assign rq_xfer  = in_valid_i && in_ready_o && (cmd_e'(cmd_i) == CMD_REMAP);
  assign out_xfer = out_valid_o && out_ready_i;

  // remaps taken in but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (rq_xfer && !out_xfer) begin
      pend_q <= pend_q + 1'b1;
    end else if (out_xfer && !rq_xfer) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(in_frame_o)
      && $stable(out_red_o) && $stable(out_green_o) && $stable(out_blue_o))
    else $error("result changed while stalled");

  a_black_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_frame_o |-> out_red_o == '0 && out_green_o == '0
      && out_blue_o == '0)
    else $error("out-of-frame result not black");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != '0)
    else $error("result without a pending remap");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pend_q) <= PEND_MAX)
    else $error("more remaps in flight than queue and pipeline hold");

endmodule

bind radial_lens_undistort_remap rlu_checker u_rlu_checker (.*);

`default_nettype wire

>>> verif/radial_lens_undistort_remap_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radial_lens_undistort_remap_tb: self-checking bench of the radial remap
// Streams store and remap transfers into the block under random idling on
// both channels, predicts every remap result from a private lens model and
// frame copy, and compares each result transfer field by field, in order.
// ----------------------------------------------------------------------------

module radial_lens_undistort_remap_tb;
  import rlu_pkg::*;

  localparam int     DRAIN_CYCLES = 40;         // queue + 8 stages + a stall
  localparam longint TIMEOUT_NS   = 5_000_000;  // watchdog time limit
  localparam longint UNITY_C48    = 64'sd1 <<< 48;
  localparam longint C48_LIMIT    = 64'sd1 <<< 61;

  // index past the last register; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;

  typedef struct packed {
    cmd_e             op;
    logic [PIX_W-1:0] col;
    logic [PIX_W-1:0] row;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
  } pix_item_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            in_frame;
  } remap_result_t;

  // ---------------------------------------------------------------------------
  // Block I/O; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic                  cmd_i       = 1'b0;
  logic [PIX_W-1:0]      pix_col_i   = '0;
  logic [PIX_W-1:0]      pix_row_i   = '0;
  logic [CH_W-1:0]       in_red_i    = '0;
  logic [CH_W-1:0]       in_green_i  = '0;
  logic [CH_W-1:0]       in_blue_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [CH_W-1:0]       out_red_o;
  logic [CH_W-1:0]       out_green_o;
  logic [CH_W-1:0]       out_blue_o;
  logic                  in_frame_o;

  radial_lens_undistort_remap i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .pix_col_i   (pix_col_i),
    .pix_row_i   (pix_row_i),
    .in_red_i    (in_red_i),
    .in_green_i  (in_green_i),
    .in_blue_i   (in_blue_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o),
    .in_frame_o  (in_frame_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Bench state
  // ---------------------------------------------------------------------------
  cfg_t            lens_cfg;                               // mirror of the registers
  logic [RGB_W-1:0] frame_model [MAX_HEIGHT][MAX_WIDTH];   // updated on transfer
  bit              src_written [MAX_HEIGHT][MAX_WIDTH];    // as planned, in queue order
  pix_item_t       pixel_q[$];                             // items not yet presented
  remap_result_t   remap_expect_q[$];                      // predicted, not yet seen
  int              mismatch_count = 0;
  bit              idle_enable    = 1'b1;
  bit              item_taken     = 1'b0;
  int              send_gap       = 0;
  int              stall_gap      = 0;

  // ---------------------------------------------------------------------------
  // Lens model
  // ---------------------------------------------------------------------------
  // Fixed-point scale: offsets in 1/16 pixel, c in 2^-48 then 2^-32, result
  // brought back to whole pixels by a shift of 36 that rounds toward zero.
  function automatic longint drop_36_to_zero(input longint x);
    if (x >= 0) return x >>> 36;
    return -((-x) >>> 36);
  endfunction

  // Returns 1 when output pixel (col,row) maps into the frame in use; the
  // source pixel comes back in src_col/src_row.
  function automatic bit lens_source(input logic [PIX_W-1:0] col, row,
                                     output logic [PIX_W-1:0] src_col, src_row);
    longint cc, cr, du, dv, r2, r4, k1, k2, c48, c32, sx, sy, w, h;
    cc  = longint'(lens_cfg.center_col);
    cr  = longint'(lens_cfg.center_row);
    k1  = longint'($signed(lens_cfg.k1));
    k2  = longint'($signed(lens_cfg.k2));
    du  = 16 * longint'(col) - cc;
    dv  = 16 * longint'(row) - cr;
    r2  = du * du + dv * dv;            // below 2^30, so r2^2 stays positive
    r4  = r2 * r2;
    c48 = UNITY_C48 + k1 * r2 + (((r4 >>> 32) * k2) >>> 8);
    if (c48 > C48_LIMIT)       c48 = C48_LIMIT;
    else if (c48 < -C48_LIMIT) c48 = -C48_LIMIT;
    c32 = c48 >>> 16;                   // floor
    sx  = drop_36_to_zero(c32 * du + (cc <<< 32));
    sy  = drop_36_to_zero(c32 * dv + (cr <<< 32));
    // a frame wider or taller than the store is clipped to the store
    w = (lens_cfg.image_width  < MAX_WIDTH)  ? longint'(lens_cfg.image_width)  : MAX_WIDTH;
    h = (lens_cfg.image_height < MAX_HEIGHT) ? longint'(lens_cfg.image_height) : MAX_HEIGHT;
    src_col = sx[PIX_W-1:0];
    src_row = sy[PIX_W-1:0];
    return (sx >= 0) && (sx < w) && (sy >= 0) && (sy < h);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus planning
  // ---------------------------------------------------------------------------
  task automatic plan_store(input logic [PIX_W-1:0] col, row, input logic [RGB_W-1:0] rgb);
    pix_item_t it;
    it.op    = CMD_STORE;
    it.col   = col;
    it.row   = row;
    it.red   = rgb[23:16];
    it.green = rgb[15:8];
    it.blue  = rgb[7:0];
    pixel_q.push_back(it);
    src_written[row][col] = 1'b1;
  endtask

  // A remap whose source was never stored gets a store of that source
  // pixel right in front of it, which also hits the write-then-read path.
  task automatic plan_remap(input logic [PIX_W-1:0] col, row);
    pix_item_t        it;
    logic [PIX_W-1:0] sx, sy;
    logic [31:0]      junk;
    if (lens_source(col, row, sx, sy) && !src_written[sy][sx])
      plan_store(sx, sy, RGB_W'($urandom));
    junk     = $urandom;            // colour fields are don't-care on a remap
    it.op    = CMD_REMAP;
    it.col   = col;
    it.row   = row;
    it.red   = junk[23:16];
    it.green = junk[15:8];
    it.blue  = junk[7:0];
    pixel_q.push_back(it);
  endtask

  // Mostly raster runs of remaps (the video use case) and single remaps,
  // with stores of random pixels mixed in. Every queued item counts,
  // stores put in front of remaps too.
  task automatic plan_random(input int count);
    int base;
    int run;
    int col;
    int row;
    base = pixel_q.size();
    while (pixel_q.size() - base < count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          plan_store(PIX_W'($urandom), PIX_W'($urandom), RGB_W'($urandom));
        end
        4, 5, 6: begin
          run = $urandom_range(4, 12);
          col = $urandom_range(0, 63);
          row = $urandom_range(0, 63);
          for (int k = 0; k < run; k++) plan_remap(PIX_W'(col + k), PIX_W'(row));
        end
        default: begin
          plan_remap(PIX_W'($urandom), PIX_W'($urandom));
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  task automatic write_lens_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      REG_K1:         lens_cfg.k1           = data;
      REG_K2:         lens_cfg.k2           = data;
      REG_CENTER_COL: lens_cfg.center_col   = data[CEN_W-1:0];
      REG_CENTER_ROW: lens_cfg.center_row   = data[CEN_W-1:0];
      REG_WIDTH:      lens_cfg.image_width  = data[DIM_W-1:0];
      REG_HEIGHT:     lens_cfg.image_height = data[DIM_W-1:0];
      default: ;
    endcase
  endtask

  // narrow registers sometimes get garbage above their field
  function automatic logic [CFG_DATA_W-1:0] pad_junk(input int unsigned value,
                                                     input int field_w);
    logic [CFG_DATA_W-1:0] upper;
    upper = $urandom_range(0, 1) ? ($urandom << field_w) : '0;
    return upper | value;
  endfunction

  task automatic set_lens(input logic [31:0] k1, k2, input int unsigned cc, cr, w, h);
    write_lens_reg(REG_SPARE, $urandom);
    write_lens_reg(REG_K1, k1);
    write_lens_reg(REG_K2, k2);
    write_lens_reg(REG_CENTER_COL, pad_junk(cc, CEN_W));
    write_lens_reg(REG_CENTER_ROW, pad_junk(cr, CEN_W));
    write_lens_reg(REG_WIDTH, pad_junk(w, DIM_W));
    write_lens_reg(REG_HEIGHT, pad_junk(h, DIM_W));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int unsigned rand_center();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 1023);
  endfunction

  function automatic int unsigned rand_dim();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(65, 127) : $urandom_range(1, 64);
  endfunction

  // Everything sent, every result back, then time for trailing stores.
  task automatic wait_idle();
    while (pixel_q.size() != 0 || in_valid_i || remap_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: presents queued items at the falling edge; payload and
  // valid hold until the transfer, and idle gaps come in random bursts.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : input_driver
    pix_item_t it;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || item_taken) begin
      item_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pixel_q.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 10);
        in_valid_i <= 1'b0;
      end else begin
        it = pixel_q.pop_front();
        in_valid_i <= 1'b1;
        cmd_i      <= it.op;
        pix_col_i  <= it.col;
        pix_row_i  <= it.row;
        in_red_i   <= it.red;
        in_green_i <= it.green;
        in_blue_i  <= it.blue;
      end
    end
  end

  // Prediction at the input transfer: stores go into the frame copy, remaps
  // queue their expected result. The block answers in order, so queue order
  // matches result order.
  always @(posedge clk_i) begin : input_monitor
    logic [PIX_W-1:0] sx, sy;
    remap_result_t    want;
    if (rst_ni && in_valid_i && in_ready_o) begin
      item_taken = 1'b1;
      if (cmd_e'(cmd_i) == CMD_STORE) begin
        frame_model[pix_row_i][pix_col_i] = {in_red_i, in_green_i, in_blue_i};
      end else begin
        want = '0;                          // outside: black, in_frame low
        if (lens_source(pix_col_i, pix_row_i, sx, sy))
          want = {frame_model[sy][sx], 1'b1};
        remap_expect_q.push_back(want);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: ready stalls in bursts, results checked at the rising edge
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : result_stall
    if (stall_gap > 0) begin
      stall_gap--;
      out_ready_i <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 5) == 0) begin
      stall_gap = $urandom_range(0, 10);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic flag_result_error(input string msg);
    if (mismatch_count < 10) $display("%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin : result_monitor
    remap_result_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {out_red_o, out_green_o, out_blue_o, in_frame_o};
      if (remap_expect_q.size() == 0) begin
        flag_result_error($sformatf("unexpected result rgb=%02h%02h%02h in_frame=%0b",
                                    got.red, got.green, got.blue, got.in_frame));
      end else begin
        want = remap_expect_q.pop_front();
        if (got.red !== want.red || got.green !== want.green ||
            got.blue !== want.blue || got.in_frame !== want.in_frame)
          flag_result_error($sformatf(
            "remap mismatch: expected rgb=%02h%02h%02h in_frame=%0b, got rgb=%02h%02h%02h in_frame=%0b",
            want.red, want.green, want.blue, want.in_frame,
            got.red, got.green, got.blue, got.in_frame));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : sequence_main
    // register values after reset
    lens_cfg.k1           = '0;
    lens_cfg.k2           = '0;
    lens_cfg.center_col   = RST_CENTER;
    lens_cfg.center_row   = RST_CENTER;
    lens_cfg.image_width  = RST_DIM;
    lens_cfg.image_height = RST_DIM;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed, on the reset settings: no distortion and the principal point
    // on pixel (32,32), so every remap reads its own pixel back.
    plan_store(0, 0, 24'h000000);
    plan_store(63, 63, 24'hFFFFFF);
    plan_store(63, 0, 24'hFF00AA);
    plan_store(0, 63, 24'h00FF55);
    plan_remap(0, 0);
    plan_remap(63, 63);
    plan_remap(63, 0);
    plan_remap(0, 63);
    plan_store(5, 7, 24'h123456);   // read right behind its write
    plan_remap(5, 7);
    plan_store(5, 7, 24'hA5C3E1);   // overwrite, then read again
    plan_remap(5, 7);
    plan_remap(32, 32);             // the principal point itself
    plan_remap(31, 33);
    wait_idle();

    // largest coefficients and a frame wider and taller than the store;
    // saturation must not pull far pixels back into the frame
    set_lens(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 127, 127);
    plan_remap(0, 0);
    plan_remap(63, 63);
    plan_random(55);
    wait_idle();

    // most negative coefficients, centre at the far corner, 1x1 frame:
    // stores outside the frame still land in the store
    set_lens(32'h8000_0000, 32'h8000_0000, 16383, 16383, 1, 1);
    plan_store(63, 63, 24'h5A5A5A);
    plan_remap(63, 63);
    plan_remap(0, 0);
    plan_random(55);
    wait_idle();

    // zero width and height: every remap comes back black
    set_lens($urandom_range(0, 32'h0400_0000) - 32'h0200_0000, $urandom, 512, 512, 0, 0);
    plan_random(40);
    wait_idle();

    // random settings; the last two phases run with no idling at all
    for (int ph = 0; ph < 8; ph++) begin
      idle_enable = (ph < 6) ? ($urandom_range(0, 3) != 0) : 1'b0;
      set_lens(($urandom_range(0, 3) == 0) ? $urandom
                 : $urandom_range(0, 32'h0800_0000) - 32'h0400_0000,
               $urandom, rand_center(), rand_center(), rand_dim(), rand_dim());
      plan_random(70);
      wait_idle();
    end

    if (mismatch_count == 0 && remap_expect_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
